/* rtl/core/i2c_sensor_burst_read_sequencer_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the I2C sensor burst-read sequencer.
// ---------------------------------------------------------------------------
`ifndef I2C_SENSOR_BURST_READ_SEQUENCER_ASSERT_SVH
`define I2C_SENSOR_BURST_READ_SEQUENCER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ISBR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sequencer assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ISBR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sequencer assertion failed");

`endif

/* rtl/core/i2csbr_pkg.sv */
// ---------------------------------------------------------------------------
// i2csbr_pkg
// Types, action and status codes for the I2C sensor burst-read sequencer.
// ---------------------------------------------------------------------------
package i2csbr_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] CFG_DEV_ADDR  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_FIRST_REG = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ENABLED   = 2'd2;

  localparam logic [6:0] DEV_ADDR_RST  = 7'd96;
  localparam logic [7:0] FIRST_REG_RST = 8'd2;

  localparam logic [2:0] ACT_NONE      = 3'd0;
  localparam logic [2:0] ACT_START     = 3'd1;
  localparam logic [2:0] ACT_SEND      = 3'd2;
  localparam logic [2:0] ACT_READ_ACK  = 3'd3;
  localparam logic [2:0] ACT_READ_NACK = 3'd4;
  localparam logic [2:0] ACT_STOP      = 3'd5;
  localparam logic [2:0] ACT_ABORT     = 3'd6;

  localparam logic [7:0] ST_START      = 8'h08;
  localparam logic [7:0] ST_RESTART    = 8'h10;
  localparam logic [7:0] ST_ADDR_W_ACK = 8'h18;
  localparam logic [7:0] ST_DATA_ACK   = 8'h28;
  localparam logic [7:0] ST_ADDR_R_ACK = 8'h40;
  localparam logic [7:0] ST_RX_ACK     = 8'h50;
  localparam logic [7:0] ST_RX_NACK    = 8'h58;

  localparam logic KIND_REQUEST = 1'b0;

  localparam logic [1:0] SLOT_HEAD_HI = 2'd0;
  localparam logic [1:0] SLOT_HEAD_LO = 2'd1;
  localparam logic [1:0] SLOT_PITCH   = 2'd2;
  localparam logic [1:0] SLOT_ROLL    = 2'd3;

  localparam logic [15:0] HEADING_ERR  = 16'hEEEE;
  localparam logic [7:0]  ANGLE_ERR    = 8'hBB;
  localparam logic [15:0] HEADING_NONE = 16'hFFFF;
  localparam logic [7:0]  ANGLE_NONE   = 8'hFF;

  typedef struct packed {
    logic       kind;
    logic [7:0] status;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  tx_byte;
    logic [15:0] heading;
    logic        heading_valid;
    logic [7:0]  pitch;
    logic        pitch_valid;
    logic [7:0]  roll;
    logic        roll_valid;
    logic        failed;
    logic        busy_res;
  } out_t;

endpackage

/* rtl/core/i2c_sensor_burst_read_sequencer.sv */
// ---------------------------------------------------------------------------
// i2c_sensor_burst_read_sequencer
// Steps an I2C master through a heading, pitch and roll burst read.
// ---------------------------------------------------------------------------
//  Channel  Direction  Handshake             Payload
//  in_      input      in_valid / in_ready    i2csbr_pkg::in_t
//  out_     output     out_valid / out_ready  i2csbr_pkg::out_t
//  cfg_     input      cfg_we                 cfg_idx, cfg_wdata
//
// Each beat's state update and result are formed in one pass and land in the
// result register on the accepting edge.
// A new beat is taken in every cycle while the result register is empty or
// being drained, so in_ready falls only while out_valid is high and out_ready
// is low. Reset is synchronous and resets sequence state and configuration.
`include "i2c_sensor_burst_read_sequencer_assert.svh"

module i2c_sensor_burst_read_sequencer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  i2csbr_pkg::in_t                     in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output i2csbr_pkg::out_t                    out_data,
  input  logic                                cfg_we,
  input  logic [i2csbr_pkg::CfgIdxW-1:0]      cfg_idx,
  input  logic [i2csbr_pkg::CfgDataW-1:0]     cfg_wdata
);

  logic [6:0]  dev_addr_r;
  logic [7:0]  first_reg_r;
  logic        enabled_r;

  logic [1:0]  slot_r,    slot_nxt;
  logic [15:0] heading_r, heading_nxt;
  logic [7:0]  pitch_r,   pitch_nxt;
  logic [7:0]  roll_r,    roll_nxt;
  logic [2:0]  ready_r,   ready_nxt;
  logic        error_r,   error_nxt;
  logic        active_r,  active_nxt;

  logic        out_valid_r;
  i2csbr_pkg::out_t out_r, out_nxt;

  logic [2:0]  action;
  logic [7:0]  tx_byte;
  logic        accept;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r  <= i2csbr_pkg::DEV_ADDR_RST;
      first_reg_r <= i2csbr_pkg::FIRST_REG_RST;
      enabled_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        i2csbr_pkg::CFG_DEV_ADDR:  dev_addr_r  <= cfg_wdata[6:0];
        i2csbr_pkg::CFG_FIRST_REG: first_reg_r <= cfg_wdata[7:0];
        i2csbr_pkg::CFG_ENABLED:   enabled_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    slot_nxt    = slot_r;
    heading_nxt = heading_r;
    pitch_nxt   = pitch_r;
    roll_nxt    = roll_r;
    ready_nxt   = ready_r;
    error_nxt   = error_r;
    active_nxt  = active_r;
    action      = i2csbr_pkg::ACT_NONE;
    tx_byte     = 8'h00;
    if (in_data.kind == i2csbr_pkg::KIND_REQUEST) begin
      if (!active_r) begin
        slot_nxt    = i2csbr_pkg::SLOT_HEAD_HI;
        heading_nxt = i2csbr_pkg::HEADING_NONE;
        pitch_nxt   = i2csbr_pkg::ANGLE_NONE;
        roll_nxt    = i2csbr_pkg::ANGLE_NONE;
        ready_nxt   = 3'b000;
        error_nxt   = 1'b0;
        active_nxt  = 1'b1;
        if (enabled_r) begin
          action = i2csbr_pkg::ACT_START;
        end
      end
    end else begin
      unique case (in_data.status)
        i2csbr_pkg::ST_START: begin
          action  = i2csbr_pkg::ACT_SEND;
          tx_byte = {dev_addr_r, 1'b0};
        end
        i2csbr_pkg::ST_ADDR_W_ACK: begin
          action  = i2csbr_pkg::ACT_SEND;
          tx_byte = first_reg_r;
        end
        i2csbr_pkg::ST_DATA_ACK: begin
          action = i2csbr_pkg::ACT_START;
        end
        i2csbr_pkg::ST_RESTART: begin
          action  = i2csbr_pkg::ACT_SEND;
          tx_byte = {dev_addr_r, 1'b1};
        end
        i2csbr_pkg::ST_ADDR_R_ACK: begin
          if (slot_r == i2csbr_pkg::SLOT_HEAD_HI) begin
            action = i2csbr_pkg::ACT_READ_ACK;
          end
        end
        i2csbr_pkg::ST_RX_ACK: begin
          unique case (slot_r)
            i2csbr_pkg::SLOT_HEAD_HI: begin
              heading_nxt = {in_data.rx_byte, 8'h00};
              slot_nxt    = i2csbr_pkg::SLOT_HEAD_LO;
              action      = i2csbr_pkg::ACT_READ_ACK;
            end
            i2csbr_pkg::SLOT_HEAD_LO: begin
              heading_nxt  = heading_r | {8'h00, in_data.rx_byte};
              ready_nxt[0] = 1'b1;
              slot_nxt     = i2csbr_pkg::SLOT_PITCH;
              action       = i2csbr_pkg::ACT_READ_ACK;
            end
            i2csbr_pkg::SLOT_PITCH: begin
              pitch_nxt    = in_data.rx_byte;
              ready_nxt[1] = 1'b1;
              slot_nxt     = i2csbr_pkg::SLOT_ROLL;
              action       = i2csbr_pkg::ACT_READ_NACK;
            end
            default: begin
              action = i2csbr_pkg::ACT_READ_ACK;
            end
          endcase
        end
        i2csbr_pkg::ST_RX_NACK: begin
          if (slot_r == i2csbr_pkg::SLOT_ROLL) begin
            roll_nxt     = in_data.rx_byte;
            ready_nxt[2] = 1'b1;
            active_nxt   = 1'b0;
            action       = i2csbr_pkg::ACT_STOP;
          end else begin
            error_nxt   = 1'b1;
            heading_nxt = i2csbr_pkg::HEADING_ERR;
            active_nxt  = 1'b0;
            action      = i2csbr_pkg::ACT_ABORT;
          end
        end
        default: begin
          error_nxt   = 1'b1;
          heading_nxt = i2csbr_pkg::HEADING_ERR;
          pitch_nxt   = i2csbr_pkg::ANGLE_ERR;
          roll_nxt    = i2csbr_pkg::ANGLE_ERR;
          active_nxt  = 1'b0;
          action      = i2csbr_pkg::ACT_ABORT;
        end
      endcase
    end

    out_nxt.action        = action;
    out_nxt.tx_byte       = tx_byte;
    out_nxt.heading       = heading_nxt;
    out_nxt.heading_valid = ready_nxt[0];
    out_nxt.pitch         = pitch_nxt;
    out_nxt.pitch_valid   = ready_nxt[1];
    out_nxt.roll          = roll_nxt;
    out_nxt.roll_valid    = ready_nxt[2];
    out_nxt.failed        = error_nxt;
    out_nxt.busy_res      = active_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= i2csbr_pkg::SLOT_HEAD_HI;
      heading_r   <= 16'h0000;
      pitch_r     <= 8'h00;
      roll_r      <= 8'h00;
      ready_r     <= 3'b000;
      error_r     <= 1'b0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        slot_r    <= slot_nxt;
        heading_r <= heading_nxt;
        pitch_r   <= pitch_nxt;
        roll_r    <= roll_nxt;
        ready_r   <= ready_nxt;
        error_r   <= error_nxt;
        active_r  <= active_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `ISBR_ASSERT_NXT(a_accept_fills_result, accept, out_valid_r)
  `ISBR_ASSERT_NOW(a_busy_matches_state, out_valid_r, out_r.busy_res == active_r)
  `ISBR_ASSERT_NOW(a_abort_sets_error,
                   out_valid_r && out_r.action == i2csbr_pkg::ACT_ABORT,
                   out_r.failed && !out_r.busy_res)
  `ISBR_ASSERT_NOW(a_stop_has_roll,
                   out_valid_r && out_r.action == i2csbr_pkg::ACT_STOP,
                   out_r.roll_valid && !out_r.busy_res && slot_r == i2csbr_pkg::SLOT_ROLL)

endmodule
